### hdl/assert_macros.svh
// Assertion macros shared by the RTL. Each macro uses the clk and rst_n of the module
// in which it is expanded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/spc_pkg.sv
package spc_pkg;

    localparam int NODES  = 9;
    localparam int NODE_W = 4;
    localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W  = 27;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 64;

    localparam logic [NODE_W-1:0] NODES_N   = NODE_W'(NODES);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_RUN  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_WALK,
        ST_DONE
    } walk_state_t;

    typedef struct packed {
        logic [NODE_W-1:0] start_node;
        logic [CNT_W-1:0]  path_count;
        logic [CNT_W-1:0]  long_count;
        logic              last;
    } spc_result_t;

endpackage

### hdl/simple_path_counter_unit.sv
// Simple path counter for a directed graph of nine nodes. A transaction with tuser 0 loads
// one adjacency row; a row index of nine or more is ignored. A transaction with tuser 1
// starts a run that walks depth first from each start node in turn and returns one result
// per start node, with tlast on the result for the final node. The walk is done by one step
// unit that reads or pushes one entry of the path stack per cycle, and each result waits
// until the output side has taken the previous one. The input side is not ready for the
// whole run.
module simple_path_counter_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: row_index[3:0], row_bits[12:4], zero fill.
    input  logic [spc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Fields from bit 0: command[0].
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: start_node[3:0], path_count[30:4], long_path_count[57:31],
    // zero fill.
    output logic [spc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);
    import spc_pkg::*;

    `include "assert_macros.svh"

    localparam int FILL_W = OUT_TDATA_W - NODE_W - 2 * CNT_W;

    logic              in_accept;
    cmd_t              command;
    logic [NODE_W-1:0] row_index;
    logic [8:0]        row_bits;
    logic              load_en;
    logic              run_go;
    logic              busy;
    logic [IDX_W-1:0]  adj_rd_idx;
    logic [NODES-1:0]  adj_rd_row;
    logic              res_valid;
    spc_result_t       result;
    logic              out_load;
    logic              m_valid_reg, m_valid_next;
    spc_result_t       m_data_reg;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign command   = cmd_t'(s_axis_tuser[0]);
    assign row_index = s_axis_tdata[3:0];
    assign row_bits  = s_axis_tdata[12:4];
    assign load_en   = in_accept && (command == CMD_LOAD) && (row_index < NODES_N);
    assign run_go    = in_accept && (command == CMD_RUN);

    spc_adj_regs u_adj
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (load_en),
        .wr_idx (row_index[IDX_W-1:0]),
        .wr_row (NODES'(row_bits)),
        .rd_idx (adj_rd_idx),
        .rd_row (adj_rd_row)
    );

    spc_walker u_walker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .run_go     (run_go),
        .busy       (busy),
        .adj_rd_idx (adj_rd_idx),
        .adj_rd_row (adj_rd_row),
        .res_valid  (res_valid),
        .result     (result),
        .res_ack    (out_load)
    );

    assign s_axis_tready = !busy;

    assign out_load     = res_valid && (!m_valid_reg || m_axis_tready);
    assign m_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{FILL_W{1'b0}}, m_data_reg.long_count,
                            m_data_reg.path_count, m_data_reg.start_node};
    assign m_axis_tlast  = m_data_reg.last;

    `SPC_ASSERT_NEXT(a_run_blocks_input, run_go, !s_axis_tready)
    `SPC_ASSERT_NEXT(a_load_shows_result, out_load, m_axis_tvalid)
    `SPC_ASSERT_SAME(a_last_is_final_node, m_axis_tvalid && m_axis_tlast,
                     m_axis_tdata[NODE_W-1:0] == LAST_NODE)

endmodule

### hdl/spc_adj_regs.sv
module spc_adj_regs
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [spc_pkg::IDX_W-1:0] wr_idx,
    input  logic [spc_pkg::NODES-1:0] wr_row,
    input  logic [spc_pkg::IDX_W-1:0] rd_idx,
    output logic [spc_pkg::NODES-1:0] rd_row
);
    import spc_pkg::*;

    logic [NODES-1:0] adj_reg [NODES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            adj_reg[wr_idx] <= wr_row;
        end
    end

    assign rd_row = adj_reg[rd_idx];

endmodule

### hdl/spc_walker.sv
module spc_walker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      run_go,
    output logic                      busy,
    output logic [spc_pkg::IDX_W-1:0] adj_rd_idx,
    input  logic [spc_pkg::NODES-1:0] adj_rd_row,
    output logic                      res_valid,
    output spc_pkg::spc_result_t      result,
    input  logic                      res_ack
);
    import spc_pkg::*;

    walk_state_t       state_reg, state_next;
    logic [NODE_W-1:0] start_reg, start_next;
    logic [NODE_W-1:0] depth_reg, depth_next;
    logic [NODES-1:0]  mask_reg, mask_next;
    logic [CNT_W-1:0]  path_reg, path_next;
    logic [CNT_W-1:0]  long_reg, long_next;

    logic [NODE_W-1:0] node_stack_reg [NODES];
    logic [NODE_W-1:0] nbr_stack_reg [NODES];

    logic [NODE_W-1:0] top_d;
    logic [NODE_W-1:0] cur_node;
    logic [NODE_W-1:0] cur_nbr;
    logic              scan_end;
    logic              take_edge;
    logic [CNT_W-1:0]  path_inc;
    logic [CNT_W-1:0]  long_inc;

    assign top_d      = depth_reg - NODE_W'(1);
    assign cur_node   = node_stack_reg[top_d[IDX_W-1:0]];
    assign cur_nbr    = nbr_stack_reg[top_d[IDX_W-1:0]];
    assign adj_rd_idx = cur_node[IDX_W-1:0];
    assign scan_end   = (cur_nbr >= NODES_N);
    assign take_edge  = !scan_end && adj_rd_row[cur_nbr[IDX_W-1:0]]
                        && !mask_reg[cur_nbr[IDX_W-1:0]] && (depth_reg < NODES_N);
    assign path_inc   = path_reg + CNT_W'(1);
    assign long_inc   = long_reg + CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        depth_next = depth_reg;
        mask_next  = mask_reg;
        path_next  = path_reg;
        long_next  = long_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (run_go)
                begin
                    start_next = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                depth_next = NODE_W'(1);
                mask_next  = NODES'(1) << start_reg[IDX_W-1:0];
                path_next  = CNT_W'(1);
                long_next  = '0;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (scan_end)
                begin
                    mask_next  = mask_reg & ~(NODES'(1) << cur_node[IDX_W-1:0]);
                    depth_next = top_d;
                    if (top_d == '0)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (take_edge)
                begin
                    depth_next = depth_reg + NODE_W'(1);
                    mask_next  = mask_reg | (NODES'(1) << cur_nbr[IDX_W-1:0]);
                    path_next  = path_inc;
                    if (depth_reg >= NODE_W'(2))
                    begin
                        long_next = long_inc;
                    end
                end
            end
            ST_DONE:
            begin
                if (res_ack)
                begin
                    if (start_reg == LAST_NODE)
                    begin
                        start_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        start_next = start_reg + NODE_W'(1);
                        state_next = ST_INIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= '0;
            depth_reg <= '0;
            mask_reg  <= '0;
            path_reg  <= '0;
            long_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            depth_reg <= depth_next;
            mask_reg  <= mask_next;
            path_reg  <= path_next;
            long_reg  <= long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_INIT)
        begin
            node_stack_reg[0] <= start_reg;
            nbr_stack_reg[0]  <= '0;
        end
        else if ((state_reg == ST_WALK) && !scan_end)
        begin
            nbr_stack_reg[top_d[IDX_W-1:0]] <= cur_nbr + NODE_W'(1);
            if (take_edge)
            begin
                node_stack_reg[depth_reg[IDX_W-1:0]] <= cur_nbr;
                nbr_stack_reg[depth_reg[IDX_W-1:0]]  <= '0;
            end
        end
    end

    assign busy              = (state_reg != ST_IDLE);
    assign res_valid         = (state_reg == ST_DONE);
    assign result.start_node = start_reg;
    assign result.path_count = path_reg;
    assign result.long_count = long_reg;
    assign result.last       = (start_reg == LAST_NODE);

endmodule

### tb/testbench.sv
module testbench;
    import spc_pkg::*;

    localparam int IDLE_LIMIT   = 5000000;
    localparam int RANDOM_ITEMS = 410;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    logic [NODES-1:0] graph_rows [NODES];
    spc_result_t      expected_counts [$];
    int               error_count;
    int               loads_sent;
    int               ignored_loads;
    int               runs_sent;
    int               results_checked;
    int               idle_cycles;
    int               rx_hold_cycles;
    bit               tx_idle_on;
    bit               rx_idle_on;
    logic [CNT_W-1:0] peak_paths;
    logic [CNT_W-1:0] peak_long;

    simple_path_counter_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void count_paths(input int origin, output logic [CNT_W-1:0] paths,
                                        output logic [CNT_W-1:0] longs);
        int               trail [NODES];
        int               cursor [NODES];
        int               depth;
        int               here;
        int               probe;
        logic [NODES-1:0] on_trail;
        trail[0]  = origin;
        cursor[0] = 0;
        depth     = 1;
        on_trail  = '0;
        on_trail[origin] = 1'b1;
        paths     = CNT_W'(1);
        longs     = '0;
        while (depth > 0)
        begin
            here  = trail[depth-1];
            probe = cursor[depth-1];
            if (probe >= NODES)
            begin
                on_trail[here] = 1'b0;
                depth--;
            end
            else
            begin
                cursor[depth-1] = probe + 1;
                if (graph_rows[here][probe] && !on_trail[probe] && depth < NODES)
                begin
                    trail[depth]    = probe;
                    cursor[depth]   = 0;
                    depth++;
                    on_trail[probe] = 1'b1;
                    paths++;
                    if (depth >= 3)
                        longs++;
                end
            end
        end
    endfunction

    function automatic void predict_item(input cmd_t cmd, input logic [NODE_W-1:0] row,
                                         input logic [NODES-1:0] bits);
        spc_result_t r;
        if (cmd == CMD_RUN)
        begin
            for (int origin = 0; origin < NODES; origin++)
            begin
                r.start_node = NODE_W'(origin);
                count_paths(origin, r.path_count, r.long_count);
                r.last = (origin == NODES - 1);
                expected_counts.insert(expected_counts.size(), r);
                if (r.path_count > peak_paths)
                    peak_paths = r.path_count;
                if (r.long_count > peak_long)
                    peak_long = r.long_count;
            end
            runs_sent++;
        end
        else if (row < NODES)
        begin
            graph_rows[row] = bits;
            loads_sent++;
        end
        else
            ignored_loads++;
    endfunction

    function automatic logic [NODES-1:0] draw_row();
        if ($urandom_range(0, 7) < 5)
            return NODES'($urandom & $urandom & $urandom);
        return NODES'($urandom & $urandom);
    endfunction

    task automatic report_error(input string line);
        $display("mismatch: %s", line);
        error_count++;
    endtask

    task automatic send_item(input cmd_t cmd, input logic [NODE_W-1:0] row,
                             input logic [NODES-1:0] bits);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({bits, row});
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (!s_axis_tready);
        predict_item(cmd, row, bits);
    endtask

    task automatic send_run();
        send_item(CMD_RUN, NODE_W'($urandom_range(0, 15)), NODES'($urandom_range(0, 511)));
    endtask

    task automatic release_bus();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_for_results();
        release_bus();
        while (expected_counts.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_graph();
        send_item(CMD_RUN, 4'hF, 9'h1FF);
    endtask

    task automatic test_row_extremes();
        send_item(CMD_LOAD, 4'd0, 9'h1FF);
        send_item(CMD_LOAD, 4'd8, 9'h1FF);
        send_item(CMD_LOAD, 4'd9, 9'h1FF);
        send_item(CMD_LOAD, 4'hF, 9'h1FF);
        send_item(CMD_RUN, 4'd0, 9'h000);
    endtask

    task automatic test_long_chain();
        for (int i = 0; i < NODES; i++)
            send_item(CMD_LOAD, NODE_W'(i), (i < NODES - 1) ? NODES'(1 << (i + 1)) : 9'h100);
        send_run();
    endtask

    task automatic test_dense_graph();
        for (int i = 0; i < NODES; i++)
            send_item(CMD_LOAD, NODE_W'(i), (i < 7) ? 9'h07F : 9'h000);
        send_run();
    endtask

    task automatic test_output_hold();
        for (int i = 0; i < NODES; i++)
            send_item(CMD_LOAD, NODE_W'(i), draw_row());
        rx_hold_cycles = 300;
        send_run();
        for (int i = 0; i < NODES; i++)
            send_item(CMD_LOAD, NODE_W'($urandom_range(0, NODES - 1)), draw_row());
        send_run();
        wait_for_results();
    endtask

    task automatic test_random_graphs();
        int made;
        int n;
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0)
            begin
                for (int i = 0; i < NODES; i++)
                    send_item(CMD_LOAD, NODE_W'(i), draw_row());
                made += NODES;
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_item(CMD_LOAD, NODE_W'($urandom_range(0, NODES - 1)), draw_row());
                made += n;
            end
            if ($urandom_range(0, 3) == 0)
                send_item(CMD_LOAD, NODE_W'($urandom_range(NODES, 15)),
                          NODES'($urandom_range(0, 511)));
            send_run();
            made++;
        end
    endtask

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, 7) : 0;
            if (rx_hold_cycles > 0)
            begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid && rx_hold_cycles == 0);
        end
    end

    always @(posedge clk)
    begin
        spc_result_t       want;
        logic [NODE_W-1:0] got_node;
        logic [CNT_W-1:0]  got_paths;
        logic [CNT_W-1:0]  got_long;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_node  = m_axis_tdata[3:0];
            got_paths = m_axis_tdata[30:4];
            got_long  = m_axis_tdata[57:31];
            if (expected_counts.size() == 0)
                report_error($sformatf("result for start node %0d with nothing expected",
                                       got_node));
            else
            begin
                want = expected_counts.pop_front();
                results_checked++;
                if (got_node !== want.start_node)
                    report_error($sformatf("start node: got %0d, expected %0d",
                                           got_node, want.start_node));
                if (got_paths !== want.path_count)
                    report_error($sformatf("path count of node %0d: got %0d, expected %0d",
                                           want.start_node, got_paths, want.path_count));
                if (got_long !== want.long_count)
                    report_error($sformatf("long count of node %0d: got %0d, expected %0d",
                                           want.start_node, got_long, want.long_count));
                if (m_axis_tlast !== want.last)
                    report_error($sformatf("last flag of node %0d: got %0b, expected %0b",
                                           want.start_node, m_axis_tlast, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transaction for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = CMD_LOAD;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        error_count     = 0;
        loads_sent      = 0;
        ignored_loads   = 0;
        runs_sent       = 0;
        results_checked = 0;
        idle_cycles     = 0;
        rx_hold_cycles  = 0;
        peak_paths      = '0;
        peak_long       = '0;
        foreach (graph_rows[i])
            graph_rows[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_graph();
        test_row_extremes();
        test_long_chain();
        test_dense_graph();
        test_output_hold();
        test_random_graphs();

        wait_for_results();
        repeat (40) @(posedge clk);
        $display("Covered %0d row loads, %0d out-of-range loads and %0d counting runs.",
                 loads_sent, ignored_loads, runs_sent);
        $display("Checked %0d per-node results; the largest were %0d paths and %0d long paths.",
                 results_checked, peak_paths, peak_long);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
